// ----- rtl/pls_pkg.sv -----
// Shared types and constants for the positional list store.
package pls_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 7;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_READ   = 3'd2,
        MODE_WRITE  = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [IDX_W-1:0]        idx;
        logic [ITEM_WIDTH-1:0]   data;
    } cell_cmd_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  position;
        logic [31:0] item_in;
    } in_t;

    typedef struct packed {
        logic [31:0] item_out;
        logic [1:0]  status;
        logic [6:0]  item_count;
    } out_t;

endpackage

// ----- rtl/pls_cell.sv -----
// One storage cell of the list: holds one entry and shifts with its neighbors.
module pls_cell (
    input  logic                             aclk,
    input  logic [pls_pkg::IDX_W-1:0]        cell_idx,
    input  pls_pkg::cell_cmd_t               cmd,
    input  logic [pls_pkg::ITEM_WIDTH-1:0]   left_entry,
    input  logic [pls_pkg::ITEM_WIDTH-1:0]   right_entry,
    output logic [pls_pkg::ITEM_WIDTH-1:0]   entry,
    output logic [pls_pkg::ITEM_WIDTH-1:0]   rd_hit
);

    logic [pls_pkg::ITEM_WIDTH-1:0] entry_reg;
    logic [pls_pkg::ITEM_WIDTH-1:0] entry_next;
    logic                           at_pos;
    logic                           above_pos;

    assign at_pos    = (cell_idx == cmd.idx);
    assign above_pos = (cell_idx > cmd.idx);

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            pls_pkg::CELL_INSERT: begin
                if (at_pos) begin
                    entry_next = cmd.data;
                end else if (above_pos) begin
                    entry_next = left_entry;
                end
            end
            pls_pkg::CELL_REMOVE: begin
                if (at_pos || above_pos) begin
                    entry_next = right_entry;
                end
            end
            pls_pkg::CELL_WRITE: begin
                if (at_pos) begin
                    entry_next = cmd.data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry  = entry_reg;
    assign rd_hit = at_pos ? entry_reg : '0;

endmodule

// ----- rtl/positional_list_store_core.sv -----
// Top level of the positional list store: request decode, cell chain and result register.
// A result appears on the m_ side in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless m_ stalls; the cells shift in parallel.
// The ready of the s_ side stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous) empties the list and the result register.
// Entry contents are not reset; entries at or beyond the item count are never read.
module positional_list_store_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pls_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pls_pkg::out_t   m_data
);

    logic [pls_pkg::CNT_W-1:0]      count_reg;
    logic [pls_pkg::CNT_W-1:0]      count_next;
    logic                           m_valid_reg;
    pls_pkg::out_t                  out_reg;
    pls_pkg::out_t                  out_next;
    pls_pkg::cell_cmd_t             cmd;
    pls_pkg::status_t               status;
    logic                           accept;
    logic [pls_pkg::CMP_W-1:0]      pos_c;
    logic [pls_pkg::CMP_W-1:0]      cnt_c;
    logic                           pos_ok;
    logic                           ins_ok;
    logic                           is_full;
    logic [pls_pkg::ITEM_WIDTH-1:0] entries [pls_pkg::CAPACITY];
    logic [pls_pkg::ITEM_WIDTH-1:0] hits [pls_pkg::CAPACITY];
    logic [pls_pkg::ITEM_WIDTH-1:0] rd_data;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    assign pos_c   = pls_pkg::CMP_W'(s_data.position);
    assign cnt_c   = pls_pkg::CMP_W'(count_reg);
    assign pos_ok  = (pos_c != '0) && (pos_c <= cnt_c);
    assign ins_ok  = (pos_c != '0) && (pos_c <= cnt_c + pls_pkg::CMP_W'(1));
    assign is_full = (cnt_c >= pls_pkg::CMP_W'(pls_pkg::CAPACITY));

    always_comb begin
        cmd.op     = pls_pkg::CELL_HOLD;
        cmd.idx    = pls_pkg::IDX_W'(pos_c - pls_pkg::CMP_W'(1));
        cmd.data   = pls_pkg::ITEM_WIDTH'(s_data.item_in);
        status     = pls_pkg::ST_OK;
        count_next = count_reg;
        case (s_data.mode)
            pls_pkg::MODE_INSERT: begin
                if (!ins_ok) begin
                    status = pls_pkg::ST_RANGE;
                end else if (is_full) begin
                    status = pls_pkg::ST_FULL;
                end else begin
                    cmd.op     = pls_pkg::CELL_INSERT;
                    count_next = count_reg + pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::MODE_REMOVE: begin
                if (!pos_ok) begin
                    status = pls_pkg::ST_RANGE;
                end else begin
                    cmd.op     = pls_pkg::CELL_REMOVE;
                    count_next = count_reg - pls_pkg::CNT_W'(1);
                end
            end
            pls_pkg::MODE_READ: begin
                if (!pos_ok) begin
                    status = pls_pkg::ST_RANGE;
                end
            end
            pls_pkg::MODE_WRITE: begin
                if (!pos_ok) begin
                    status = pls_pkg::ST_RANGE;
                end else begin
                    cmd.op = pls_pkg::CELL_WRITE;
                end
            end
            pls_pkg::MODE_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status = pls_pkg::ST_OK;
            end
        endcase
        if (!accept) begin
            cmd.op = pls_pkg::CELL_HOLD;
        end
    end

    for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_cell
        logic [pls_pkg::ITEM_WIDTH-1:0] left_entry;
        logic [pls_pkg::ITEM_WIDTH-1:0] right_entry;

        if (i == 0) begin : g_first
            assign left_entry = '0;
        end else begin : g_mid_l
            assign left_entry = entries[i-1];
        end
        if (i == pls_pkg::CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_mid_r
            assign right_entry = entries[i+1];
        end

        pls_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (pls_pkg::IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .rd_hit      (hits[i])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
            rd_data = rd_data | hits[i];
        end
    end

    always_comb begin
        out_next.item_out   = '0;
        out_next.status     = status;
        out_next.item_count = 7'(count_next);
        if ((s_data.mode == pls_pkg::MODE_READ) && pos_ok) begin
            out_next.item_out = 32'(rd_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
        else $error("item count exceeds capacity");

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.item_count == 7'(count_reg)))
        else $error("reported item count differs from stored count");

    a_full_only_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == pls_pkg::ST_FULL)) |->
        (m_data.item_count == 7'(pls_pkg::CAPACITY)))
        else $error("list full reported below capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.mode == pls_pkg::MODE_CLEAR)) |=> (count_reg == '0))
        else $error("clear left entries in the list");

endmodule

// ----- tb/pls_result_checker.sv -----
// Checker for the positional list store: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps

module pls_result_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  pls_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  pls_pkg::out_t  m_data,
    output int             fail_count,
    output int             pending
);

    logic [pls_pkg::ITEM_WIDTH-1:0] list_words [pls_pkg::CAPACITY];
    int                             list_len;
    pls_pkg::out_t                  predicted_answers [$];
    int                             errors;

    function automatic pls_pkg::out_t apply_request(input pls_pkg::in_t req);
        pls_pkg::out_t res;
        int            pos;
        int            i;
        res = '0;
        pos = int'(req.position);
        case (req.mode)
            pls_pkg::MODE_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    res.status = pls_pkg::ST_RANGE;
                end else if (list_len >= pls_pkg::CAPACITY) begin
                    res.status = pls_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i >= pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos - 1] = req.item_in[pls_pkg::ITEM_WIDTH-1:0];
                    list_len++;
                end
            end
            pls_pkg::MODE_REMOVE: begin
                if (pos < 1 || pos > list_len) begin
                    res.status = pls_pkg::ST_RANGE;
                end else begin
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            pls_pkg::MODE_READ: begin
                if (pos < 1 || pos > list_len)
                    res.status = pls_pkg::ST_RANGE;
                else
                    res.item_out = 32'(list_words[pos - 1]);
            end
            pls_pkg::MODE_WRITE: begin
                if (pos < 1 || pos > list_len)
                    res.status = pls_pkg::ST_RANGE;
                else
                    list_words[pos - 1] = req.item_in[pls_pkg::ITEM_WIDTH-1:0];
            end
            pls_pkg::MODE_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.item_count = 7'(list_len);
        return res;
    endfunction

    always @(posedge aclk) begin
        pls_pkg::out_t want;
        if (!aresetn) begin
            list_len = 0;
            predicted_answers.delete();
        end else begin
            if (s_valid && s_ready)
                predicted_answers.push_back(apply_request(s_data));
            if (m_valid && m_ready) begin
                if (predicted_answers.size() == 0) begin
                    $error({"result transaction with no request outstanding: ",
                            "item_out %0h status %0d item_count %0d"},
                           m_data.item_out, m_data.status, m_data.item_count);
                    errors++;
                end else begin
                    want = predicted_answers.pop_front();
                    if (m_data.item_out !== want.item_out) begin
                        $error("item_out: expected %0h, actual %0h", want.item_out, m_data.item_out);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.item_count !== want.item_count) begin
                        $error("item_count: expected %0d, actual %0d",
                               want.item_count, m_data.item_count);
                        errors++;
                    end
                end
            end
        end
        pending    <= predicted_answers.size();
        fail_count <= errors;
    end

endmodule

// ----- tb/tb_positional_list_store_core.sv -----
// Testbench top for the positional list store: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 100ps

module tb_positional_list_store_core;

    localparam int STAGE_ITEMS = 634;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 4000;

    typedef enum int {
        BURST_GROW,
        BURST_SHRINK,
        BURST_MIX
    } burst_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    pls_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    pls_pkg::out_t m_data;

    int fail_count;
    int pending;

    int send_idle_pct = 23;
    int recv_idle_pct = 84;
    int stage         = 0;
    int items_sent    = 0;
    int hold_mark     = 32'h7fffffff;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int fill_level    = 0;
    int stall_cycles;

    positional_list_store_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pls_result_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // A long hold-off in the final stage fills the result register and stalls the input.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stage == 2 && !hold_done && items_sent >= hold_mark) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic pls_pkg::in_t make_req(input logic [2:0] mode, input int pos,
                                              input logic [31:0] data);
        pls_pkg::in_t req;
        req.mode     = mode;
        req.position = 7'(pos);
        req.item_in  = data;
        return req;
    endfunction

    task automatic send_request(input pls_pkg::in_t req);
        int pos;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent <= items_sent + 1;
        pos = int'(req.position);
        case (req.mode)
            pls_pkg::MODE_INSERT:
                if (pos >= 1 && pos <= fill_level + 1 && fill_level < pls_pkg::CAPACITY)
                    fill_level++;
            pls_pkg::MODE_REMOVE:
                if (pos >= 1 && pos <= fill_level)
                    fill_level--;
            pls_pkg::MODE_CLEAR:
                fill_level = 0;
            default: begin
            end
        endcase
    endtask

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        pls_pkg::in_t plan [$];
        pls_pkg::in_t req;
        burst_t       burst;
        int           burst_left;
        int           r;
        int           span;
        int           sel;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan.push_back(make_req(pls_pkg::MODE_READ,   1,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_REMOVE, 1,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 0,   32'hdeadbeef));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 2,   32'hdeadbeef));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 1,   32'hffffffff));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 1,   32'h00000000));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 3,   32'ha5a5a5a5));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 2,   32'h5a5a5a5a));
        plan.push_back(make_req(pls_pkg::MODE_INSERT, 6,   32'h11111111));
        plan.push_back(make_req(pls_pkg::MODE_READ,   1,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_READ,   4,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_READ,   5,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_WRITE,  0,   32'h87654321));
        plan.push_back(make_req(pls_pkg::MODE_WRITE,  2,   32'h12345678));
        plan.push_back(make_req(pls_pkg::MODE_WRITE,  127, 32'hffffffff));
        plan.push_back(make_req(pls_pkg::MODE_READ,   2,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_REMOVE, 5,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_REMOVE, 1,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_REMOVE, 3,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_READ,   0,   32'h0));
        plan.push_back(make_req(3'd5,                 127, 32'hffffffff));
        plan.push_back(make_req(3'd6,                 64,  32'h0));
        plan.push_back(make_req(3'd7,                 1,   32'hffffffff));
        plan.push_back(make_req(pls_pkg::MODE_CLEAR,  127, 32'hffffffff));
        plan.push_back(make_req(pls_pkg::MODE_READ,   1,   32'h0));
        plan.push_back(make_req(pls_pkg::MODE_CLEAR,  0,   32'h0));
        foreach (plan[k])
            send_request(plan[k]);

        burst      = BURST_GROW;
        burst_left = 0;
        for (int st = 0; st < 3; st++) begin
            case (st)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct <= 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct <= 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    hold_mark     <= items_sent + 80;
                end
            endcase
            stage <= st;
            for (int n = 0; n < STAGE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    burst      = burst_t'($urandom_range(2));
                    burst_left = $urandom_range(40, 150);
                end
                burst_left--;
                r = $urandom_range(99);
                if ($urandom_range(99) < 10) begin
                    req.mode     = 3'($urandom_range(7));
                    req.position = 7'($urandom_range(127));
                end else begin
                    case (burst)
                        BURST_GROW:
                            req.mode = (r < 80) ? pls_pkg::MODE_INSERT :
                                       (r < 88) ? pls_pkg::MODE_READ :
                                       (r < 95) ? pls_pkg::MODE_WRITE :
                                       pls_pkg::MODE_REMOVE;
                        BURST_SHRINK:
                            req.mode = (r < 65) ? pls_pkg::MODE_REMOVE :
                                       (r < 80) ? pls_pkg::MODE_INSERT :
                                       (r < 90) ? pls_pkg::MODE_READ :
                                       pls_pkg::MODE_WRITE;
                        default:
                            req.mode = (r < 35) ? pls_pkg::MODE_INSERT :
                                       (r < 65) ? pls_pkg::MODE_REMOVE :
                                       (r < 80) ? pls_pkg::MODE_READ :
                                       (r < 95) ? pls_pkg::MODE_WRITE :
                                       pls_pkg::MODE_CLEAR;
                    endcase
                    span = (req.mode == pls_pkg::MODE_INSERT) ? fill_level + 1 : fill_level;
                    if (span < 1)
                        span = 1;
                    sel = $urandom_range(3);
                    if (sel == 0)
                        req.position = 7'd1;
                    else if (sel == 1)
                        req.position = 7'(span);
                    else
                        req.position = 7'($urandom_range(span, 1));
                end
                req.item_in = $urandom();
                send_request(req);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/positional_list_store_core.sv
tb/pls_result_checker.sv
tb/tb_positional_list_store_core.sv
